@@ sv/csvt_pkg.sv @@
package csvt_pkg;

   localparam int BYTE_BITS = 8;

   // byte codes the scanner tests against
   localparam logic [BYTE_BITS-1:0] CH_QUOTE = 8'h22;
   localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_BITS-1:0] CH_SPACE = 8'h20;

   // register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CFG_DELIMITER   = 1'b0;
   localparam logic CFG_REPLACEMENT = 1'b1;
   localparam logic [BYTE_BITS-1:0] DELIMITER_RESET   = 8'h2C;
   localparam logic [BYTE_BITS-1:0] REPLACEMENT_RESET = 8'h7E;

   // result kinds
   localparam logic KIND_VALUE     = 1'b0;
   localparam logic KIND_FIELD_END = 1'b1;

   // scanner to result buffer hand-over
   typedef struct packed {
      logic push;   // load new results this cycle
      logic pair;   // two results instead of one
   } push_ctl_type;

endpackage

@@ sv/csvt_req_if.sv @@
interface csvt_req_if;

   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);

endinterface

@@ sv/csvt_rsp_if.sv @@
interface csvt_rsp_if #(
   parameter int COLUMN_BITS = 8,
   parameter int ROW_BITS    = 16
);

   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [7:0]             value_byte;
   logic [COLUMN_BITS-1:0] column_index;
   logic [ROW_BITS-1:0]    row_index;
   logic                   row_end;
   logic                   last_of_run;

   modport source (output valid, output kind, output value_byte, output column_index,
                   output row_index, output row_end, output last_of_run, input ready);
   modport sink (input valid, input kind, input value_byte, input column_index,
                 input row_index, input row_end, input last_of_run, output ready);

endinterface

@@ sv/csvt_csr.sv @@
module csvt_csr
   import csvt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output logic [BYTE_BITS-1:0]     delimiter,
   output logic [BYTE_BITS-1:0]     replacement
);

   logic [BYTE_BITS-1:0] delimiter_ff;
   logic [BYTE_BITS-1:0] replacement_ff;
   logic                 write_en;
   logic                 reg_index;

   assign write_en  = psel && penable && pwrite;
   assign reg_index = paddr[2];
   assign pready    = 1'b1;

   // write on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff   <= DELIMITER_RESET;
         replacement_ff <= REPLACEMENT_RESET;
      end else if (write_en) begin
         case (reg_index)
            CFG_DELIMITER:   delimiter_ff   <= pwdata[BYTE_BITS-1:0];
            CFG_REPLACEMENT: replacement_ff <= pwdata[BYTE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      case (reg_index)
         CFG_DELIMITER:   prdata[BYTE_BITS-1:0] = delimiter_ff;
         CFG_REPLACEMENT: prdata[BYTE_BITS-1:0] = replacement_ff;
         default:         prdata = '0;
      endcase
   end

   assign delimiter   = delimiter_ff;
   assign replacement = replacement_ff;

endmodule

@@ sv/csvt_scan.sv @@
module csvt_scan
   import csvt_pkg::*;
#(
   parameter int COLUMN_BITS = 8,
   parameter int ROW_BITS    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // item in
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [BYTE_BITS-1:0]   in_data_byte,
   input  logic                   in_last_byte,
   // configuration
   input  logic [BYTE_BITS-1:0]   delimiter,
   input  logic [BYTE_BITS-1:0]   replacement,
   // result slots
   input  logic                   room,
   output push_ctl_type           ctl,
   output logic                   s0_kind,
   output logic [BYTE_BITS-1:0]   s0_value,
   output logic [COLUMN_BITS-1:0] s0_column,
   output logic [ROW_BITS-1:0]    s0_row,
   output logic                   s0_row_end,
   output logic                   s0_last,
   output logic [COLUMN_BITS-1:0] s1_column,
   output logic [ROW_BITS-1:0]    s1_row
);

   localparam logic [1:0] MODE_OUT      = 2'd0;
   localparam logic [1:0] MODE_IN       = 2'd1;
   localparam logic [1:0] MODE_QPEND    = 2'd2;
   localparam logic [1:0] MODE_AFTER_CR = 2'd3;

   localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;
   localparam logic [ROW_BITS-1:0]    ROW_MAX = '1;

   // input register
   logic                 in_valid_ff;
   logic [BYTE_BITS-1:0] byte_ff;
   logic                 last_ff;

   // scanner state
   logic [1:0]             mode_ff, mode_in;
   logic                   row_open_ff, row_open_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;

   logic                   act_value;
   logic                   act_field;
   logic                   act_line;
   logic [BYTE_BITS-1:0]   act_byte;
   logic                   flush;
   logic                   first_res;
   logic                   consume;
   logic [1:0]             mode_mid;
   logic                   row_open_mid;
   logic [COLUMN_BITS-1:0] col_mid;
   logic [ROW_BITS-1:0]    row_mid;

   // classify the byte against mode and configuration
   always_comb begin
      logic outside;
      outside   = 1'b0;
      act_value = 1'b0;
      act_field = 1'b0;
      act_line  = 1'b0;
      act_byte  = byte_ff;
      mode_mid  = MODE_OUT;
      case (mode_ff)
         MODE_IN: begin
            if (byte_ff == CH_QUOTE) begin
               mode_mid = MODE_QPEND;
            end else begin
               mode_mid  = MODE_IN;
               act_value = 1'b1;
            end
         end
         MODE_QPEND: begin
            if (byte_ff == CH_QUOTE) begin
               mode_mid  = MODE_IN;
               act_value = 1'b1;
            end else begin
               outside = 1'b1;
            end
         end
         MODE_AFTER_CR: begin
            outside = (byte_ff != CH_LF);
         end
         default: begin
            outside = 1'b1;
         end
      endcase

      if (outside) begin
         if (byte_ff == CH_QUOTE) begin
            mode_mid = MODE_IN;
         end else if (byte_ff == delimiter) begin
            act_field = 1'b1;
         end else if (byte_ff == CH_CR || byte_ff == CH_LF) begin
            act_line = row_open_ff;
            if (byte_ff == CH_CR) begin
               mode_mid = MODE_AFTER_CR;
            end
         end else if (byte_ff < CH_SPACE && byte_ff != CH_TAB) begin
            act_value = 1'b1;
            act_byte  = replacement;
         end else begin
            act_value = 1'b1;
         end
      end
   end

   // state after the byte's own action
   always_comb begin
      row_open_mid = row_open_ff;
      col_mid      = col_ff;
      row_mid      = row_ff;
      if (act_value) begin
         row_open_mid = 1'b1;
      end else if (act_field) begin
         row_open_mid = 1'b1;
         col_mid      = (col_ff == COL_MAX) ? col_ff : col_ff + COLUMN_BITS'(1);
      end else if (act_line) begin
         row_open_mid = 1'b0;
         col_mid      = '0;
         row_mid      = (row_ff == ROW_MAX) ? row_ff : row_ff + ROW_BITS'(1);
      end
   end

   assign first_res = act_value || act_field || act_line;
   assign flush     = last_ff && row_open_mid;

   // drive the result slots
   always_comb begin
      ctl.push   = consume && (first_res || flush);
      ctl.pair   = first_res && flush;
      s1_column  = col_mid;
      s1_row     = row_mid;
      if (first_res) begin
         s0_kind    = act_value ? KIND_VALUE : KIND_FIELD_END;
         s0_value   = act_value ? act_byte : '0;
         s0_column  = col_ff;
         s0_row     = row_ff;
         s0_row_end = act_line;
         s0_last    = !flush;
      end else begin
         s0_kind    = KIND_FIELD_END;
         s0_value   = '0;
         s0_column  = col_mid;
         s0_row     = row_mid;
         s0_row_end = 1'b1;
         s0_last    = 1'b1;
      end
   end

   // advance when results fit, or when the byte yields none
   assign consume  = in_valid_ff && (room || !(first_res || flush));
   assign in_ready = !in_valid_ff || consume;

   // next state; the final byte clears everything
   always_comb begin
      mode_in     = mode_ff;
      row_open_in = row_open_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (consume) begin
         if (last_ff) begin
            mode_in     = MODE_OUT;
            row_open_in = 1'b0;
            col_in      = '0;
            row_in      = '0;
         end else begin
            mode_in     = mode_mid;
            row_open_in = row_open_mid;
            col_in      = col_mid;
            row_in      = row_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_OUT;
         row_open_ff <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= in_valid;
         end
         mode_ff     <= mode_in;
         row_open_ff <= row_open_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

   // hold the item payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         byte_ff <= in_data_byte;
         last_ff <= in_last_byte;
      end
   end

endmodule

@@ sv/csvt_rbuf.sv @@
module csvt_rbuf
   import csvt_pkg::*;
#(
   parameter int WIDTH = 35
) (
   input  logic             clock,
   input  logic             reset,
   input  push_ctl_type     ctl,
   input  logic [WIDTH-1:0] slot0,
   input  logic [WIDTH-1:0] slot1,
   output logic             room,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] res0_ff;
   logic [WIDTH-1:0] res1_ff;
   logic [1:0]       count_ff;
   logic             pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = res0_ff;
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff == 2'd0) || (count_ff == 2'd1 && out_ready);

   // track how many results wait
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (ctl.push) begin
         count_ff <= ctl.pair ? 2'd2 : 2'd1;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   // load a new pair or shift the second result forward
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         res0_ff <= slot0;
         res1_ff <= slot1;
      end else if (pop) begin
         res0_ff <= res1_ff;
      end
   end

endmodule

@@ sv/csv_field_tokenizer.sv @@
// Channel   Port    Direction  Carries
// --------  ------  ---------  ---------------------------------------------------
// request   req_if  in         data_byte, last_byte
// response  rsp_if  out        kind, value_byte, column_index, row_index, row_end,
//                              last_of_run
// config    csr_*   in/out     APB registers: delimiter at 0x0, replacement at 0x4
//
// An item is held in the input register, then its results load into a two-entry
// result buffer once it has room; the first result is presented from the buffer's
// head and can be taken at the next edge. One item is taken per cycle while each
// yields at most one result and rsp_if does not stall; an item with two results
// (a byte plus the flush on the final byte) fills the buffer, and the next item
// waits for the first to be taken. A stall on rsp_if backs up through the result
// buffer and the input register to req_if.ready. Synchronous reset clears the
// scanner state and the registers to comma and tilde; no clearing pass is needed.
module csv_field_tokenizer
   import csvt_pkg::*;
#(
   parameter int COLUMN_BITS = 8,
   parameter int ROW_BITS    = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   csvt_req_if.sink                 req_if,
   csvt_rsp_if.source               rsp_if,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int RES_BITS = 1 + BYTE_BITS + COLUMN_BITS + ROW_BITS + 1 + 1;

   logic [BYTE_BITS-1:0]   delimiter;
   logic [BYTE_BITS-1:0]   replacement;
   logic                   room;
   push_ctl_type           ctl;
   logic                   s0_kind;
   logic [BYTE_BITS-1:0]   s0_value;
   logic [COLUMN_BITS-1:0] s0_column;
   logic [ROW_BITS-1:0]    s0_row;
   logic                   s0_row_end;
   logic                   s0_last;
   logic [COLUMN_BITS-1:0] s1_column;
   logic [ROW_BITS-1:0]    s1_row;
   logic [RES_BITS-1:0]    slot0;
   logic [RES_BITS-1:0]    slot1;
   logic [RES_BITS-1:0]    out_data;

   csvt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .pready      (csr_pready),
      .delimiter   (delimiter),
      .replacement (replacement)
   );

   csvt_scan #(
      .COLUMN_BITS (COLUMN_BITS),
      .ROW_BITS    (ROW_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_if.valid),
      .in_ready     (req_if.ready),
      .in_data_byte (req_if.data_byte),
      .in_last_byte (req_if.last_byte),
      .delimiter    (delimiter),
      .replacement  (replacement),
      .room         (room),
      .ctl          (ctl),
      .s0_kind      (s0_kind),
      .s0_value     (s0_value),
      .s0_column    (s0_column),
      .s0_row       (s0_row),
      .s0_row_end   (s0_row_end),
      .s0_last      (s0_last),
      .s1_column    (s1_column),
      .s1_row       (s1_row)
   );

   // pack results; the second slot is always the closing row end
   assign slot0 = {s0_kind, s0_value, s0_column, s0_row, s0_row_end, s0_last};
   assign slot1 = {KIND_FIELD_END, {BYTE_BITS{1'b0}}, s1_column, s1_row, 1'b1, 1'b1};

   csvt_rbuf #(
      .WIDTH (RES_BITS)
   ) u_rbuf (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .slot0     (slot0),
      .slot1     (slot1),
      .room      (room),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (out_data)
   );

   assign {rsp_if.kind, rsp_if.value_byte, rsp_if.column_index, rsp_if.row_index,
           rsp_if.row_end, rsp_if.last_of_run} = out_data;

endmodule
